/* sv/pct_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pct_pkg
// Shared types, constants and codes for the PPS capture/match tracker.
// ----------------------------------------------------------------------------
package pct_pkg;

	localparam int DATA_W    = 32;
	localparam int FREQ_W    = 28;
	localparam int PRIME_W   = 8;
	localparam int CORR_W    = 23;
	localparam int CFG_W     = 28;
	localparam int CFG_IDX_W = 2;
	localparam int PACT_W    = 2;

	localparam logic [FREQ_W-1:0]  FREQ_RESET  = FREQ_W'(24000000);
	localparam logic [PRIME_W-1:0] PRIME_RESET = PRIME_W'(60);
	localparam logic [DATA_W-1:0]  NS_PER_S    = DATA_W'(1000000000);
	localparam logic [DATA_W-1:0]  MILLI       = DATA_W'(1000);

	// x / 1000 == (x * MILLI_RECIP) >> MILLI_SHIFT for every 32-bit x
	localparam logic [DATA_W-1:0]  MILLI_RECIP = DATA_W'(274877907);
	localparam int                 MILLI_SHIFT = 38;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FREQ      = 2'd0,
		CFG_PRIME     = 2'd1,
		CFG_OUT_TIMER = 2'd2
	} cfg_idx_t;

	// priming action codes
	typedef enum logic [PACT_W-1:0] {
		PACT_NONE   = 2'd0,
		PACT_SYNC   = 2'd1,
		PACT_RELOAD = 2'd2
	} prime_act_t;

	typedef struct packed {
		logic              match_flag;
		logic              capture_flag;
		logic [DATA_W-1:0] captured_count;
		logic [DATA_W-1:0] service_count;
	} pct_item_t;

	typedef struct packed {
		logic              pps_pulse;
		logic [CORR_W-1:0] correction_ns;
		logic              match_write;
		logic [DATA_W-1:0] match_value;
		logic [PACT_W-1:0] prime_action;
		logic              phase_valid;
		logic [DATA_W-1:0] phase_diff;
		logic [DATA_W-1:0] capture_total;
		logic [DATA_W-1:0] match_total;
		logic              is_primed;
	} pct_result_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic do_match;
		logic do_khz;
		logic div_start;
		logic do_mul;
		logic take_corr;
		logic do_capt;
		logic do_fold;
		logic write_out;
	} pct_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_corr;
		logic div_done;
		logic fold_needed;
		logic res_room;
	} pct_status_t;

endpackage

/* sv/pct_item_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pct_item_if
// Request channel carrying one timer interrupt item.
// ----------------------------------------------------------------------------
interface pct_item_if import pct_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              match_flag;
	logic              capture_flag;
	logic [DATA_W-1:0] captured_count;
	logic [DATA_W-1:0] service_count;

	modport source (output valid, match_flag, capture_flag, captured_count,
		service_count, input ready);
	modport sink (input valid, match_flag, capture_flag, captured_count,
		service_count, output ready);
endinterface

/* sv/pct_result_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pct_result_if
// Result channel carrying one tracker result per request.
// ----------------------------------------------------------------------------
interface pct_result_if import pct_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              pps_pulse;
	logic [CORR_W-1:0] correction_ns;
	logic              match_write;
	logic [DATA_W-1:0] match_value;
	logic [PACT_W-1:0] prime_action;
	logic              phase_valid;
	logic [DATA_W-1:0] phase_diff;
	logic [DATA_W-1:0] capture_total;
	logic [DATA_W-1:0] match_total;
	logic              is_primed;

	modport source (output valid, pps_pulse, correction_ns, match_write,
		match_value, prime_action, phase_valid, phase_diff, capture_total,
		match_total, is_primed, input ready);
	modport sink (input valid, pps_pulse, correction_ns, match_write,
		match_value, prime_action, phase_valid, phase_diff, capture_total,
		match_total, is_primed, output ready);
endinterface

/* sv/pct_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pct_div
// Iterative restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pct_div import pct_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DATA_W-1:0] dividend,
	input  logic [DATA_W-1:0] divisor,
	output logic              done,
	output logic [DATA_W-1:0] quotient
);
	localparam int CNT_W = $clog2(DATA_W);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(DATA_W - 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0] dvs_q;
	logic [DATA_W:0]   shifted;
	logic [DATA_W:0]   trial;

	// shift in the next dividend bit and try a subtract
	assign shifted = {rem_q, quo_q[DATA_W-1]};
	assign trial   = shifted - {1'b0, dvs_q};

	// control: busy flag, step count, done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: remainder and quotient shift
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[DATA_W]) begin
				rem_q <= trial[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

/* sv/pct_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pct_datapath
// Tracker state, configuration, correction arithmetic and result register.
// ----------------------------------------------------------------------------
module pct_datapath import pct_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  pct_item_t            item_data,
	input  pct_cmd_t             cmd,
	output pct_status_t          status,
	output pct_result_t          result_data,
	output logic                 result_valid,
	input  logic                 result_ready
);
	// configuration
	logic [FREQ_W-1:0]  freq_q;
	logic [PRIME_W-1:0] prime_cnt_q;
	logic               has_timer_q;

	// tracker state
	logic [DATA_W-1:0] next_match_q;
	logic [DATA_W-1:0] last_match_q;
	logic [DATA_W-1:0] cap_cnt_q;
	logic [DATA_W-1:0] match_cnt_q;
	logic              primed_q;

	// current request and working values
	pct_item_t         item_q;
	logic [DATA_W-1:0] delta_q;
	logic [DATA_W-1:0] khz_q;
	logic [DATA_W-1:0] prod_q;
	logic [DATA_W-1:0] fold1_q;
	pct_result_t       acc_q;
	pct_result_t       out_q;
	logic              out_valid_q;

	logic [DATA_W-1:0]   freq_ext;
	logic [DATA_W-1:0]   half;
	logic [DATA_W-1:0]   match_sum;
	logic [DATA_W-1:0]   cap_inc;
	logic                prime_now;
	logic [DATA_W-1:0]   diff0;
	logic [DATA_W-1:0]   mag0;
	logic [DATA_W-1:0]   step1;
	logic [DATA_W-1:0]   step2;
	logic [DATA_W-1:0]   recip_in;
	logic [2*DATA_W-1:0] recip_full;
	logic [DATA_W-1:0]   milli_quot;
	logic [DATA_W-1:0]   quot;
	logic [DATA_W-1:0]   mul_lo;
	logic                div_done;
	pct_result_t         out_d;

	assign freq_ext  = {{(DATA_W-FREQ_W){1'b0}}, freq_q};
	assign half      = {{(DATA_W-FREQ_W+1){1'b0}}, freq_q[FREQ_W-1:1]};
	assign match_sum = next_match_q + freq_ext;
	assign cap_inc   = cap_cnt_q + 1'b1;
	assign prime_now = (cap_inc > {{(DATA_W-PRIME_W){1'b0}}, prime_cnt_q}) && !primed_q;

	// first fold step: pull a large negative difference up by one second
	assign diff0 = last_match_q - item_q.captured_count;
	assign mag0  = diff0[DATA_W-1] ? (~diff0 + 1'b1) : diff0;
	assign step1 = (diff0[DATA_W-1] && (mag0 > half)) ? (diff0 + freq_ext) : diff0;

	// second fold step: pull a large positive difference down by one second
	assign step2 = (!fold1_q[DATA_W-1] && (fold1_q != '0) && (fold1_q > half)) ?
		(fold1_q - freq_ext) : fold1_q;

	// divide by 1000 through the reciprocal: frequency for kHz, product for ns
	assign recip_in   = cmd.do_khz ? freq_ext : prod_q;
	assign recip_full = recip_in * MILLI_RECIP;
	assign milli_quot = {{(MILLI_SHIFT-DATA_W){1'b0}}, recip_full[2*DATA_W-1:MILLI_SHIFT]};

	// ps per count: one second divided by the kHz rate
	pct_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (NS_PER_S),
		.divisor  (khz_q),
		.done     (div_done),
		.quotient (quot)
	);

	assign mul_lo = delta_q * quot;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q      <= FREQ_RESET;
			prime_cnt_q <= PRIME_RESET;
			has_timer_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FREQ:      freq_q      <= cfg_data[FREQ_W-1:0];
				CFG_PRIME:     prime_cnt_q <= cfg_data[PRIME_W-1:0];
				CFG_OUT_TIMER: has_timer_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// tracker state: advance on match, count and prime on capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_match_q <= {{(DATA_W-FREQ_W){1'b0}}, FREQ_RESET};
			last_match_q <= '0;
			cap_cnt_q    <= '0;
			match_cnt_q  <= '0;
			primed_q     <= 1'b0;
		end else begin
			if (cmd.do_match && item_q.match_flag) begin
				last_match_q <= next_match_q;
				next_match_q <= match_sum;
				if (primed_q) begin
					match_cnt_q <= match_cnt_q + 1'b1;
				end
			end
			if (cmd.do_capt && item_q.capture_flag) begin
				cap_cnt_q <= cap_inc;
				if (prime_now) begin
					last_match_q <= '0;
					next_match_q <= freq_ext;
					match_cnt_q  <= cap_inc;
					primed_q     <= 1'b1;
				end
			end
		end
	end

	// per-request working registers and result fields
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item_data;
			acc_q  <= '0;
		end
		if (cmd.do_match && item_q.match_flag) begin
			delta_q           <= item_q.service_count - next_match_q;
			acc_q.match_write <= 1'b1;
			acc_q.match_value <= match_sum;
			if (primed_q) begin
				acc_q.pps_pulse <= 1'b1;
			end
		end
		// kHz rate saturates at one for very slow timers
		if (cmd.do_khz) begin
			khz_q <= (milli_quot == '0) ? DATA_W'(1) : milli_quot;
		end
		if (cmd.do_mul) begin
			prod_q <= mul_lo;
		end
		if (cmd.take_corr) begin
			acc_q.correction_ns <= milli_quot[CORR_W-1:0];
		end
		if (cmd.do_capt && item_q.capture_flag) begin
			if (prime_now) begin
				acc_q.match_write  <= 1'b1;
				acc_q.match_value  <= freq_ext;
				acc_q.prime_action <= has_timer_q ? PACT_SYNC : PACT_RELOAD;
			end else begin
				fold1_q <= step1;
			end
		end
		if (cmd.do_fold) begin
			acc_q.phase_valid <= 1'b1;
			acc_q.phase_diff  <= step2;
		end
	end

	// result register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.write_out) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// merge the totals into the finished result
	always_comb begin
		out_d               = acc_q;
		out_d.capture_total = cap_cnt_q;
		out_d.match_total   = match_cnt_q;
		out_d.is_primed     = primed_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.write_out) begin
			out_q <= out_d;
		end
	end

	assign status.need_corr   = item_q.match_flag && primed_q;
	assign status.div_done    = div_done;
	assign status.fold_needed = item_q.capture_flag && !prime_now;
	assign status.res_room    = !out_valid_q || result_ready;

	assign result_data  = out_q;
	assign result_valid = out_valid_q;
endmodule

/* sv/pct_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pct_ctrl
// Sequencer for one request: match, opt. correction, capture, opt. fold, write.
// ----------------------------------------------------------------------------
module pct_ctrl import pct_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  pct_status_t status,
	output pct_cmd_t    cmd
);
	typedef enum logic [9:0] {
		ST_IDLE   = 10'b0000000001,
		ST_MATCH  = 10'b0000000010,
		ST_KHZ    = 10'b0000000100,
		ST_DSTART = 10'b0000001000,
		ST_DWAIT  = 10'b0000010000,
		ST_MUL    = 10'b0000100000,
		ST_CORR   = 10'b0001000000,
		ST_CAPT   = 10'b0010000000,
		ST_FOLD   = 10'b0100000000,
		ST_WRITE  = 10'b1000000000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign item_ready = (state_q == ST_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_MATCH;
				end
			end
			ST_MATCH: begin
				cmd.do_match = 1'b1;
				state_d      = status.need_corr ? ST_KHZ : ST_CAPT;
			end
			ST_KHZ: begin
				cmd.do_khz = 1'b1;
				state_d    = ST_DSTART;
			end
			ST_DSTART: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DWAIT;
			end
			ST_DWAIT: begin
				if (status.div_done) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.do_mul = 1'b1;
				state_d    = ST_CORR;
			end
			ST_CORR: begin
				cmd.take_corr = 1'b1;
				state_d       = ST_CAPT;
			end
			ST_CAPT: begin
				cmd.do_capt = 1'b1;
				state_d     = status.fold_needed ? ST_FOLD : ST_WRITE;
			end
			ST_FOLD: begin
				cmd.do_fold = 1'b1;
				state_d     = ST_WRITE;
			end
			ST_WRITE: begin
				if (status.res_room) begin
					cmd.write_out = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

/* sv/pps_capture_match_tracker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_capture_match_tracker
// Tracks PPS capture/match timer interrupts and derives event corrections.
// ----------------------------------------------------------------------------
// Usage:
//   item   : one timer interrupt request (match/capture flags, captured
//            counter, counter at service), valid/ready.
//   result : one result per request, valid/ready, held in an output register.
//   cfg_*  : write-only register port (frequency, prime count, output timer);
//            write only while no request is in flight.
// Each accepted request is loaded, then steps through match, capture, an
//   optional phase fold and the write to the result register. A primed
//   match adds the latency correction between match and capture: kHz rate
//   by reciprocal multiply, a 32-step division for the ps-per-count scale,
//   a multiply, and the ns scaling by reciprocal multiply.
// Throughput: one request at a time; the next one is taken once the result
//   has moved to the output register, so a stalled receiver holds at most
//   one finished result while the next request is worked on, and a second
//   stall stops the sequencer before the result write.
// Reset: configuration returns to 24 MHz, 60 captures, no output timer; the
//   next match is one second out and all counters and the primed flag clear.
// ----------------------------------------------------------------------------
module pps_capture_match_tracker import pct_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	pct_item_if.sink             item,
	pct_result_if.source         result
);
	pct_cmd_t    cmd;
	pct_status_t status;
	pct_item_t   item_data;
	pct_result_t result_data;
	logic        item_ready;
	logic        result_valid;

	assign item.ready               = item_ready;
	assign item_data.match_flag     = item.match_flag;
	assign item_data.capture_flag   = item.capture_flag;
	assign item_data.captured_count = item.captured_count;
	assign item_data.service_count  = item.service_count;

	pct_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item_ready),
		.status     (status),
		.cmd        (cmd)
	);

	pct_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_data    (item_data),
		.cmd          (cmd),
		.status       (status),
		.result_data  (result_data),
		.result_valid (result_valid),
		.result_ready (result.ready)
	);

	// drive the result channel
	assign result.valid         = result_valid;
	assign result.pps_pulse     = result_data.pps_pulse;
	assign result.correction_ns = result_data.correction_ns;
	assign result.match_write   = result_data.match_write;
	assign result.match_value   = result_data.match_value;
	assign result.prime_action  = result_data.prime_action;
	assign result.phase_valid   = result_data.phase_valid;
	assign result.phase_diff    = result_data.phase_diff;
	assign result.capture_total = result_data.capture_total;
	assign result.match_total   = result_data.match_total;
	assign result.is_primed     = result_data.is_primed;

	// one request at a time
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready) |=> !item.ready)
		else $error("request accepted while another is in flight");

	// a PPS event always comes with a match register rewrite
	a_event_writes_match: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.pps_pulse) |-> result.match_write)
		else $error("PPS event without match write");

	// priming rewrites the match register, sets the primed flag and reports no phase difference
	a_prime_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && (result.prime_action != PACT_NONE)) |->
		(result.is_primed && result.match_write && !result.phase_valid))
		else $error("inconsistent priming result");

	// a phase difference is reported only with its valid flag
	a_phase_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.phase_valid) |-> (result.phase_diff == '0))
		else $error("phase difference without phase valid");
endmodule
